// ===== rtl/ledfg_pkg.sv =====
// Shared types and constants for the LED strip frame generator.
package ledfg_pkg;

  localparam int unsigned CNT_W = 9;  // led count, pixel counter, frame count
  localparam int unsigned BC_W  = 6;  // byte counter, up to 32 end bytes
  localparam int unsigned EL_W  = 6;  // end frame length
  localparam int unsigned CFG_W = 9;  // configuration write data

  localparam logic [7:0]      BYTE_ZERO    = 8'h00;
  localparam logic [7:0]      BYTE_ONES    = 8'hFF;
  localparam logic [BC_W-1:0] START_BYTES  = BC_W'(4);
  localparam logic [BC_W-1:0] PIXEL_BYTES  = BC_W'(4);
  localparam logic [9:0]      END_ROUND    = 10'd15;
  localparam int unsigned     END_SHIFT    = 4;

  typedef enum logic [1:0] {
    CMD_SET_PIXEL = 2'd0,
    CMD_START     = 2'd1,
    CMD_TICK      = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_LED_COUNT  = 2'd0,
    REG_RED_SLOT   = 2'd1,
    REG_GREEN_SLOT = 2'd2,
    REG_BLUE_SLOT  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_PIXEL = 4'b0100,
    PH_END   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic set_pixel;
    logic start;
    logic tick;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic frame_active;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/ledfg_ctrl.sv =====
// Controller: store clearing after reset, item accept and result hand-off.
module ledfg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             in_cmd_i,
  input  ledfg_pkg::dp_status_t  status_i,
  output ledfg_pkg::ctrl_cmd_t   cmd_o
);
  import ledfg_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.set_pixel = (in_cmd_i == CMD_SET_PIXEL);
          cmd_o.start     = (in_cmd_i == CMD_START);
          // a tick with no frame armed gives nothing
          if (in_cmd_i == CMD_TICK && status_i.frame_active) begin
            cmd_o.tick = 1'b1;
            state_d    = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  a_tick_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick |=> (state_q == ST_EMIT))
    else $error("tick did not move to emit");

  a_no_cmd_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !(cmd_o.set_pixel || cmd_o.start || cmd_o.tick))
    else $error("item taken during store clear");

endmodule

// ===== rtl/ledfg_dpath.sv =====
// Datapath: configuration registers, pixel store, frame counters, output register.
module ledfg_dpath #(
  parameter int unsigned MAX_LEDS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [ledfg_pkg::CFG_W-1:0] cfg_data_i,
  input  ledfg_pkg::in_item_t         in_item_i,
  input  ledfg_pkg::ctrl_cmd_t        cmd_i,
  output ledfg_pkg::dp_status_t       status_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ledfg_pkg::out_item_t        out_item_o
);
  import ledfg_pkg::*;

  localparam int unsigned IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  // configuration
  logic [CNT_W-1:0] led_count_q;
  logic [1:0]       red_slot_q, green_slot_q, blue_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q  <= CNT_W'(1);
      red_slot_q   <= 2'd0;
      green_slot_q <= 2'd1;
      blue_slot_q  <= 2'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LED_COUNT:  led_count_q  <= cfg_data_i;
        REG_RED_SLOT:   red_slot_q   <= cfg_data_i[1:0];
        REG_GREEN_SLOT: green_slot_q <= cfg_data_i[1:0];
        REG_BLUE_SLOT:  blue_slot_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // clamp the count to 1..MAX_LEDS
  logic [CNT_W-1:0] eff_count;
  always_comb begin
    if (led_count_q == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(led_count_q) > MAX_LEDS) begin
      eff_count = CNT_W'(MAX_LEDS);
    end else begin
      eff_count = led_count_q;
    end
  end

  // frame state
  phase_e           phase_q, phase_d;
  logic [BC_W-1:0]  bc_q, bc_d, bc_inc;
  logic [CNT_W-1:0] pc_q, pc_d, pc_inc;
  logic [CNT_W-1:0] frame_cnt_q;
  logic [EL_W-1:0]  end_len;
  logic [7:0]       tick_byte;
  logic             tick_last, tick_mem;
  logic [1:0]       tick_lane;

  assign bc_inc  = bc_q + BC_W'(1);
  assign pc_inc  = pc_q + CNT_W'(1);
  assign end_len = EL_W'((10'(frame_cnt_q) + END_ROUND) >> END_SHIFT);

  always_comb begin
    phase_d   = phase_q;
    bc_d      = bc_q;
    pc_d      = pc_q;
    tick_byte = BYTE_ONES;
    tick_last = 1'b0;
    tick_mem  = 1'b0;
    tick_lane = 2'(bc_q - BC_W'(1));
    if (cmd_i.start && phase_q == PH_IDLE) begin
      phase_d = PH_START;
      bc_d    = '0;
      pc_d    = '0;
    end else if (cmd_i.tick) begin
      unique case (phase_q)
        PH_START: begin
          tick_byte = BYTE_ZERO;
          bc_d      = bc_inc;
          if (bc_inc >= START_BYTES) begin
            phase_d = PH_PIXEL;
            bc_d    = '0;
            pc_d    = '0;
          end
        end
        PH_PIXEL: begin
          // header byte first, then three stored bytes
          tick_mem = (bc_q != '0);
          bc_d     = bc_inc;
          if (bc_inc >= PIXEL_BYTES) begin
            bc_d = '0;
            pc_d = pc_inc;
            if (pc_inc >= frame_cnt_q) begin
              phase_d = PH_END;
              pc_d    = '0;
            end
          end
        end
        PH_END: begin
          bc_d = bc_inc;
          if (EL_W'(bc_inc) >= end_len) begin
            tick_last = 1'b1;
            phase_d   = PH_IDLE;
            bc_d      = '0;
            pc_d      = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bc_q        <= '0;
      pc_q        <= '0;
      frame_cnt_q <= CNT_W'(1);
    end else begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      pc_q    <= pc_d;
      if (cmd_i.start && phase_q == PH_IDLE) begin
        frame_cnt_q <= eff_count;
      end
    end
  end

  // pixel store, one byte lane per wire slot
  logic [2:0][7:0]  mem [MAX_LEDS];
  logic [IDX_W-1:0] clr_q;
  logic [IDX_W-1:0] wr_addr;
  logic             set_ok;
  logic [2:0][7:0]  wr_data;
  logic [2:0]       wr_en;
  logic [2:0][7:0]  rd_q;

  assign wr_addr = IDX_W'(in_item_i.pixel_index);
  assign set_ok  = cmd_i.set_pixel && (phase_q == PH_IDLE)
                   && (in_item_i.pixel_index < 16'(eff_count));

  // later colour wins a shared slot
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wr_data[k] = in_item_i.red;
      wr_en[k]   = 1'b0;
      priority if (blue_slot_q == 2'(k)) begin
        wr_data[k] = in_item_i.blue;
        wr_en[k]   = 1'b1;
      end else if (green_slot_q == 2'(k)) begin
        wr_data[k] = in_item_i.green;
        wr_en[k]   = 1'b1;
      end else if (red_slot_q == 2'(k)) begin
        wr_data[k] = in_item_i.red;
        wr_en[k]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem[clr_q] <= '0;
    end else if (set_ok) begin
      for (int k = 0; k < 3; k++) begin
        if (wr_en[k]) begin
          mem[wr_addr][k] <= wr_data[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      rd_q <= mem[IDX_W'(pc_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + IDX_W'(1);
    end
  end

  // pending result between tick and hand-off
  logic [7:0] pend_byte_q;
  logic       pend_last_q, pend_mem_q;
  logic [1:0] pend_lane_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      pend_byte_q <= tick_byte;
      pend_last_q <= tick_last;
      pend_mem_q  <= tick_mem;
      pend_lane_q <= tick_lane;
    end
  end

  // output register
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_byte <= pend_mem_q ? rd_q[pend_lane_q] : pend_byte_q;
      out_q.last     <= pend_last_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_item_o             = out_q;
  assign status_o.clear_done    = (clr_q == IDX_W'(MAX_LEDS - 1));
  assign status_o.frame_active  = (phase_q != PH_IDLE);
  assign status_o.out_free      = !out_valid_q || !out_stall_i;

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("frame phase not one-hot");

  a_idle_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (bc_q == '0 && pc_q == '0))
    else $error("counters not cleared in idle phase");

  a_last_is_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.tick && tick_last) |-> (tick_byte == BYTE_ONES && !tick_mem))
    else $error("last byte is not an end byte");

  a_pixel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIXEL) |-> (pc_q < frame_cnt_q && bc_q < PIXEL_BYTES))
    else $error("pixel counters out of range");

endmodule

// ===== rtl/rgb_led_strip_frame_generator.sv =====
// Top level of the LED strip frame generator.
// After reset the pixel store is zeroed by a clearing pass over every address, during
// which in_stall_o stays high (configuration writes are taken at any time). Then a
// set pixel, start, reserved item or a tick with no frame armed is done in ST_IDLE,
// while a tick with a frame armed first reads the pixel store and then, in ST_EMIT,
// loads the output register; that load is held while a previous byte still waits at
// a stalled output. The output register holds its byte until the sink takes it while
// the next item is already accepted. A frame is four 0x00 bytes, 0xFF plus three
// stored bytes per LED, and ceil(count/16) 0xFF bytes, the final one flagged by last.
module rgb_led_strip_frame_generator #(
  parameter int unsigned MAX_LEDS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ledfg_pkg::in_item_t         in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ledfg_pkg::out_item_t        out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [ledfg_pkg::CFG_W-1:0] cfg_data_i
);
  import ledfg_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  ledfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_cmd_i   (in_item_i.cmd),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ledfg_dpath #(
    .MAX_LEDS (MAX_LEDS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== tb/sv/ledfg_frame_checker.sv =====
// Checker that predicts and compares the serial bytes of the LED strip frame generator.
`timescale 1ns / 100ps
module ledfg_frame_checker #(
  parameter int unsigned MAX_LEDS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  ledfg_pkg::in_item_t         in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  ledfg_pkg::out_item_t        out_item_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [ledfg_pkg::CFG_W-1:0] cfg_data_i,
  output int unsigned                 mismatch_cnt_o,
  output int unsigned                 pending_o
);
  import ledfg_pkg::*;

  logic [7:0]  wire_bytes [MAX_LEDS][3];
  phase_e      phase_q;
  int unsigned pixel_cnt_q;
  int unsigned byte_cnt_q;
  int unsigned frame_leds_q;
  logic [8:0]  led_count_q;
  logic [1:0]  red_slot_q;
  logic [1:0]  green_slot_q;
  logic [1:0]  blue_slot_q;
  out_item_t   serial_q [$];
  int unsigned fail_total = 0;

  assign mismatch_cnt_o = fail_total;

  task automatic flag_mismatch(input string what);
    $display("%0t ledfg_frame_checker: %s", $realtime, what);
    fail_total++;
  endtask

  // Zero and oversized counts clamp to the valid range.
  function automatic int unsigned leds_in_use();
    if (led_count_q == '0) return 1;
    if (led_count_q > MAX_LEDS) return MAX_LEDS;
    return int'(led_count_q);
  endfunction

  task automatic paint_slot(input logic [15:0] idx, input logic [1:0] slot, input logic [7:0] v);
    if (slot < 2'd3) wire_bytes[idx][slot] = v;
  endtask

  task automatic predict_serial_byte();
    out_item_t   nb;
    int unsigned end_len;
    nb.out_byte = BYTE_ZERO;
    nb.last     = 1'b0;
    case (phase_q)
      PH_START: begin
        byte_cnt_q++;
        if (byte_cnt_q >= START_BYTES) begin
          phase_q     = PH_PIXEL;
          byte_cnt_q  = 0;
          pixel_cnt_q = 0;
        end
      end
      PH_PIXEL: begin
        nb.out_byte = (byte_cnt_q == 0) ? BYTE_ONES : wire_bytes[pixel_cnt_q][byte_cnt_q - 1];
        byte_cnt_q++;
        if (byte_cnt_q >= PIXEL_BYTES) begin
          byte_cnt_q = 0;
          pixel_cnt_q++;
          if (pixel_cnt_q >= frame_leds_q) begin
            phase_q     = PH_END;
            pixel_cnt_q = 0;
          end
        end
      end
      default: begin
        end_len     = (frame_leds_q + END_ROUND) >> END_SHIFT;
        nb.out_byte = BYTE_ONES;
        byte_cnt_q++;
        if (byte_cnt_q >= end_len) begin
          nb.last     = 1'b1;
          phase_q     = PH_IDLE;
          byte_cnt_q  = 0;
          pixel_cnt_q = 0;
        end
      end
    endcase
    serial_q.push_back(nb);
  endtask

  task automatic apply_command(input in_item_t it);
    case (it.cmd)
      CMD_SET_PIXEL: begin
        if (phase_q == PH_IDLE && it.pixel_index < leds_in_use()) begin
          // later colors win on a shared slot
          paint_slot(it.pixel_index, red_slot_q, it.red);
          paint_slot(it.pixel_index, green_slot_q, it.green);
          paint_slot(it.pixel_index, blue_slot_q, it.blue);
        end
      end
      CMD_START: begin
        if (phase_q == PH_IDLE) begin
          frame_leds_q = leds_in_use();
          phase_q      = PH_START;
          pixel_cnt_q  = 0;
          byte_cnt_q   = 0;
        end
      end
      CMD_TICK: begin
        if (phase_q != PH_IDLE) predict_serial_byte();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      foreach (wire_bytes[i, j]) wire_bytes[i][j] = '0;
      phase_q      = PH_IDLE;
      pixel_cnt_q  = 0;
      byte_cnt_q   = 0;
      frame_leds_q = 1;
      led_count_q  = 9'd1;
      red_slot_q   = 2'd0;
      green_slot_q = 2'd1;
      blue_slot_q  = 2'd2;
      serial_q.delete();
      pending_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_LED_COUNT:  led_count_q  = cfg_data_i[8:0];
          REG_RED_SLOT:   red_slot_q   = cfg_data_i[1:0];
          REG_GREEN_SLOT: green_slot_q = cfg_data_i[1:0];
          REG_BLUE_SLOT:  blue_slot_q  = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) apply_command(in_item_i);
      if (out_valid_i && !out_stall_i) begin
        if (serial_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h last %0b",
                                  out_item_i.out_byte, out_item_i.last));
        end else begin
          want = serial_q.pop_front();
          if (out_item_i.out_byte !== want.out_byte)
            flag_mismatch($sformatf("out_byte %02h, want %02h",
                                    out_item_i.out_byte, want.out_byte));
          if (out_item_i.last !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                    out_item_i.last, want.last, want.out_byte));
        end
      end
      pending_o <= serial_q.size();
    end
  end

endmodule

// ===== tb/sv/rgb_led_strip_frame_generator_tb.sv =====
// Stimulus and verdict for the LED strip frame generator.
`timescale 1ns / 100ps
module rgb_led_strip_frame_generator_tb;
  import ledfg_pkg::*;

  localparam int unsigned MAX_LEDS    = 256;
  localparam int unsigned RAND_ITEMS  = 800;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned IDLE_GUARD  = 8;
  localparam logic [1:0]  CMD_RESERVED = 2'd3;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_LIGHT,
    SINK_HEAVY,
    SINK_TOGGLE
  } sink_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall_o;
  in_item_t         in_item = '0;
  logic             out_valid_o;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index = REG_LED_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;

  int unsigned mismatches;
  int unsigned in_flight;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  logic [8:0]  cur_count = 9'd1;
  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned mode_left = 0;

  rgb_led_strip_frame_generator #(
    .MAX_LEDS(MAX_LEDS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ledfg_frame_checker #(
    .MAX_LEDS(MAX_LEDS)
  ) frame_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall_o),
    .in_item_i      (in_item),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall),
    .out_item_i     (out_item),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .mismatch_cnt_o (mismatches),
    .pending_o      (in_flight)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sink stalls in open, light, heavy and toggle modes, switching mode at random.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(0, 3));
      mode_left <= $urandom_range(32, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:  out_stall <= 1'b0;
      SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      SINK_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("rgb_led_strip_frame_generator_tb: errors");
    $finish;
  end

  function automatic int unsigned frame_ticks(input logic [8:0] count);
    int unsigned eff;
    eff = (count == '0) ? 1 : (count > MAX_LEDS) ? MAX_LEDS : count;
    return 4 + 4 * eff + (eff + 15) / 16;
  endfunction

  function automatic in_item_t rand_item(input logic [1:0] cmd);
    in_item_t it;
    it.cmd         = cmd;
    it.pixel_index = 16'($urandom_range(0, 65535));
    it.red         = 8'($urandom_range(0, 255));
    it.green       = 8'($urandom_range(0, 255));
    it.blue        = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic logic [1:0] pick_slot();
    return ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
  endfunction

  // Send one item; drop valid for a random gap once a burst runs out.
  task automatic push(input in_item_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
  endtask

  // Hold off until every expected byte has come out.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
    repeat (IDLE_GUARD) @(posedge clk_i);
  endtask

  task automatic write_regs(input bit count_only, input logic [8:0] count,
                            input logic [1:0] rs, input logic [1:0] gs, input logic [1:0] bs);
    cfg_reg_e         regs [4] = '{REG_LED_COUNT, REG_RED_SLOT, REG_GREEN_SLOT, REG_BLUE_SLOT};
    logic [CFG_W-1:0] vals [4];
    vals[0] = count;
    vals[1] = {7'($urandom), rs};
    vals[2] = {7'($urandom), gs};
    vals[3] = {7'($urandom), bs};
    foreach (regs[i]) begin
      if (!count_only || regs[i] == REG_LED_COUNT) begin
        cfg_valid <= 1'b1;
        cfg_index <= regs[i];
        cfg_data  <= vals[i];
        do @(posedge clk_i); while (!cfg_ready_o);
      end
    end
    cfg_valid <= 1'b0;
    cur_count = count;
  endtask

  task automatic run_frames(input int unsigned frames, inout int unsigned useful);
    in_item_t    it;
    int unsigned eff;
    logic [1:0]  busy_noise [3] = '{CMD_SET_PIXEL, CMD_START, CMD_RESERVED};
    eff = (cur_count == '0) ? 1 : (cur_count > MAX_LEDS) ? MAX_LEDS : cur_count;
    repeat (frames) begin
      repeat ($urandom_range(0, (eff < 12) ? eff + 2 : 12)) begin
        it = rand_item(CMD_SET_PIXEL);
        case ($urandom_range(0, 15))
          0:       ;  // keep the random, mostly out-of-range index
          1:       it.pixel_index = 16'(eff);
          default: it.pixel_index = 16'($urandom_range(0, eff - 1));
        endcase
        push(it);
        useful++;
      end
      if ($urandom_range(0, 3) == 0)
        push(rand_item(($urandom_range(0, 1) == 0) ? CMD_TICK : CMD_RESERVED));
      push(rand_item(CMD_START));
      useful++;
      repeat (frame_ticks(cur_count)) begin
        if ($urandom_range(0, 9) == 0) push(rand_item(busy_noise[$urandom_range(0, 2)]));
        push(rand_item(CMD_TICK));
        useful++;
      end
    end
  endtask

  initial begin
    in_item_t    it;
    int unsigned useful;
    int unsigned frame_len;
    int unsigned roll;
    logic [8:0]  count;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;

    // Zero count acts as one LED; red and green share a slot, blue is off.
    write_regs(1'b0, 9'd0, 2'd2, 2'd2, 2'd3);
    it = '{CMD_SET_PIXEL, 16'd0, 8'hFF, 8'h5A, 8'h00};
    push(it);
    it = '{CMD_SET_PIXEL, 16'hFFFF, 8'h00, 8'hFF, 8'hFF};
    push(it);
    it.pixel_index = 16'd1;
    push(it);
    push(rand_item(CMD_TICK));
    it = '{CMD_RESERVED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF};
    push(it);
    frame_len = frame_ticks(cur_count);
    push(rand_item(CMD_START));
    repeat (2) push(rand_item(CMD_TICK));
    // Change the count while the frame is armed; it must keep its latched length.
    settle();
    write_regs(1'b1, 9'd511, 2'd0, 2'd0, 2'd0);
    it = '{CMD_SET_PIXEL, 16'd0, 8'hFF, 8'hFF, 8'hFF};
    push(it);
    push(rand_item(CMD_START));
    repeat (frame_len - 2) push(rand_item(CMD_TICK));
    it = '{CMD_SET_PIXEL, 16'd255, 8'h11, 8'h22, 8'h33};
    push(it);
    it.pixel_index = 16'd256;
    push(it);
    settle();

    useful = 0;
    while (useful < RAND_ITEMS) begin
      roll = $urandom_range(0, 15);
      if (roll == 0)     count = 9'd0;
      else if (roll < 3) count = 9'($urandom_range(17, 80));
      else               count = 9'($urandom_range(1, 16));
      write_regs(1'b0, count, pick_slot(), pick_slot(), pick_slot());
      run_frames($urandom_range(1, 3), useful);
      settle();
    end

    if (mismatches == 0)
      $display("rgb_led_strip_frame_generator_tb: clean");
    else
      $display("rgb_led_strip_frame_generator_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ledfg_pkg.sv
rtl/ledfg_ctrl.sv
rtl/ledfg_dpath.sv
rtl/rgb_led_strip_frame_generator.sv
tb/sv/ledfg_frame_checker.sv
tb/sv/rgb_led_strip_frame_generator_tb.sv
